[rtl/rfas_pkg.sv]
package rfas_pkg;

  localparam int CounterBits = 32;
  localparam int NumCounters = 12;
  localparam int CountIdxBits = $clog2(NumCounters);

  localparam logic [15:0] CaptureLimitReset = 16'd1024;

  // register index on the configuration port
  localparam logic RegCaptureLimit = 1'b0;

  // event kinds
  localparam logic [1:0] KindFrame   = 2'd0;
  localparam logic [1:0] KindRelease = 2'd1;
  localparam logic [1:0] KindRead    = 2'd2;

  // frame types
  localparam logic [2:0] TypeMgmt = 3'd0;
  localparam logic [2:0] TypeCtrl = 3'd1;
  localparam logic [2:0] TypeData = 3'd2;

  // verdicts
  localparam logic [2:0] VerdictQueued    = 3'd0;
  localparam logic [2:0] VerdictMisc      = 3'd1;
  localparam logic [2:0] VerdictError     = 3'd2;
  localparam logic [2:0] VerdictPoolEmpty = 3'd3;
  localparam logic [2:0] VerdictQueueFull = 3'd4;
  localparam logic [2:0] VerdictNonFrame  = 3'd5;

  // statistic indexes
  localparam int CntTotal  = 0;
  localparam int CntMgmt   = 1;
  localparam int CntCtrl   = 2;
  localparam int CntData   = 3;
  localparam int CntMisc   = 4;
  localparam int CntErr    = 5;
  localparam int CntPool   = 6;
  localparam int CntQFull  = 7;
  localparam int CntQueued = 8;
  localparam int CntTrunc  = 9;
  localparam int CntEmpty  = 10;
  localparam int CntProc   = 11;

  localparam logic [3:0] SelOccupancy = 4'd12;
  localparam logic [3:0] SelPeak      = 4'd13;

  typedef logic [CounterBits-1:0] counter_t;

endpackage

[rtl/rx_frame_admission_stats.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | kind, frame_type, rx_error, signal_length,
//         |           |                       | payload_length, slot_available,
//         |           |                       | queue_accepts, counter_index
// out     | output    | out_valid / out_ready | verdict, copy_length, was_truncated,
//         |           |                       | empty_payload, return_slot, occupancy,
//         |           |                       | counter_value
// cfg     | APB       | psel / penable        | capture_limit at byte address 0
//
// One event per cycle unless the result stalls; an event passes the input, then the result register.
// The input register feeds one pass of compare and increment logic that
// writes the statistics and the result register in the same cycle.
// rst is synchronous: statistics and occupancy clear, capture_limit to 1024.
// A stalled result holds the pipeline; in_ready drops only when both the
// input register and the result register are full and out_ready is low.
module rx_frame_admission_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [2:0]  frame_type,
  input  logic        rx_error,
  input  logic [15:0] signal_length,
  input  logic [15:0] payload_length,
  input  logic        slot_available,
  input  logic        queue_accepts,
  input  logic [3:0]  counter_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [15:0] copy_length,
  output logic        was_truncated,
  output logic        empty_payload,
  output logic        return_slot,
  output logic [15:0] occupancy,
  output logic [31:0] counter_value
);
  import rfas_pkg::*;

  logic [15:0] capture_limit;

  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [2:0]  s1_type;
  logic        s1_err;
  logic [15:0] s1_sig;
  logic [15:0] s1_pay;
  logic        s1_slot;
  logic        s1_qok;
  logic [3:0]  s1_sel;

  counter_t    counters [NumCounters];
  logic [15:0] queue_occupancy;
  logic [15:0] occupancy_peak;

  logic                   s1_move;
  logic [NumCounters-1:0] inc;
  logic [2:0]             verdict_next;
  logic [15:0]            copy_next;
  logic                   trunc_next;
  logic                   empty_next;
  logic                   ret_next;
  logic [15:0]            occupancy_next;
  logic [15:0]            peak_next;
  logic [31:0]            cval_next;
  logic [15:0]            lim_len;
  logic [15:0]            len;
  logic                   over_limit;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegCaptureLimit) begin
      prdata = {16'd0, capture_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_limit <= CaptureLimitReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegCaptureLimit) begin
      capture_limit <= pwdata[15:0];
    end
  end

  // pipeline control
  assign s1_move  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_type <= frame_type;
      s1_err  <= rx_error;
      s1_sig  <= signal_length;
      s1_pay  <= payload_length;
      s1_slot <= slot_available;
      s1_qok  <= queue_accepts;
      s1_sel  <= counter_index;
    end
  end

  assign over_limit = s1_sig > capture_limit;
  assign lim_len    = over_limit ? capture_limit : s1_sig;
  assign len        = (lim_len > s1_pay) ? s1_pay : lim_len;

  always_comb begin
    inc            = '0;
    verdict_next   = VerdictNonFrame;
    copy_next      = '0;
    trunc_next     = 1'b0;
    empty_next     = 1'b0;
    ret_next       = 1'b0;
    occupancy_next = queue_occupancy;
    peak_next      = occupancy_peak;
    cval_next      = '0;
    unique case (s1_kind)
      KindFrame: begin
        inc[CntTotal] = 1'b1;
        if (s1_type != TypeMgmt && s1_type != TypeCtrl && s1_type != TypeData) begin
          inc[CntMisc] = 1'b1;
          verdict_next = VerdictMisc;
        end else begin
          inc[CntMgmt] = (s1_type == TypeMgmt);
          inc[CntCtrl] = (s1_type == TypeCtrl);
          inc[CntData] = (s1_type == TypeData);
          priority if (s1_err) begin
            inc[CntErr]  = 1'b1;
            verdict_next = VerdictError;
          end else if (!s1_slot) begin
            inc[CntPool] = 1'b1;
            verdict_next = VerdictPoolEmpty;
          end else if (!s1_qok) begin
            inc[CntQFull] = 1'b1;
            verdict_next  = VerdictQueueFull;
            ret_next      = 1'b1;
          end else begin
            verdict_next    = VerdictQueued;
            copy_next       = len;
            inc[CntQueued]  = 1'b1;
            inc[CntTrunc]   = over_limit;
            trunc_next      = over_limit;
            inc[CntEmpty]   = (len == 16'd0);
            empty_next      = (len == 16'd0);
            // saturate at the top
            if (queue_occupancy != 16'hFFFF) begin
              occupancy_next = queue_occupancy + 16'd1;
            end
            if (occupancy_next > occupancy_peak) begin
              peak_next = occupancy_next;
            end
          end
        end
      end
      KindRelease: begin
        inc[CntProc] = 1'b1;
        ret_next     = 1'b1;
        if (queue_occupancy != 16'd0) begin
          occupancy_next = queue_occupancy - 16'd1;
        end
      end
      KindRead: begin
        if (s1_sel < 4'(NumCounters)) begin
          cval_next = 32'(counters[s1_sel[CountIdxBits-1:0]]);
        end else if (s1_sel == SelOccupancy) begin
          cval_next = {16'd0, queue_occupancy};
        end else if (s1_sel == SelPeak) begin
          cval_next = {16'd0, occupancy_peak};
        end
      end
      default: begin
        // unused kind: nothing changes
      end
    endcase
  end

  // statistics update as the event leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCounters; i++) begin
        counters[i] <= '0;
      end
      queue_occupancy <= '0;
      occupancy_peak  <= '0;
    end else if (s1_valid && s1_move) begin
      for (int i = 0; i < NumCounters; i++) begin
        if (inc[i]) begin
          counters[i] <= counters[i] + 1'b1;
        end
      end
      queue_occupancy <= occupancy_next;
      occupancy_peak  <= peak_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      verdict       <= verdict_next;
      copy_length   <= copy_next;
      was_truncated <= trunc_next;
      empty_payload <= empty_next;
      return_slot   <= ret_next;
      occupancy     <= occupancy_next;
      counter_value <= cval_next;
    end
  end

endmodule

[rtl/rfas_checker.sv]
module rfas_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic [15:0] copy_length,
  input logic        was_truncated,
  input logic        empty_payload,
  input logic        return_slot,
  input logic [15:0] occupancy,
  input logic [31:0] counter_value
);
  import rfas_pkg::*;

  // only a queued frame carries copy length and length flags
  a_copy_only_queued: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VerdictQueued |->
      copy_length == 16'd0 && !was_truncated && !empty_payload)
    else $error("length fields set on a frame that was not queued");

  // empty flag matches the captured length
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VerdictQueued |-> empty_payload == (copy_length == 16'd0))
    else $error("empty payload flag disagrees with copy length");

  // a slot goes back only on queue refusal or a non-frame event
  a_return_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && return_slot |->
      verdict == VerdictQueueFull || verdict == VerdictNonFrame)
    else $error("slot returned on a frame verdict that keeps none");

  // statistic value only on a non-frame event
  a_counter_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VerdictNonFrame |-> counter_value == 32'd0)
    else $error("statistic value on a frame verdict");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(verdict))
    else $error("result changed while stalled");

endmodule

bind rx_frame_admission_stats rfas_checker u_rfas_checker (.*);

[test/rx_frame_admission_stats_tb.sv]
module rx_frame_admission_stats_tb;
  import rfas_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [2:0] TypeMiscLow = 3'd3;
  localparam logic [2:0] TypeMiscHigh = 3'd7;
  localparam logic [3:0] SelOutOfRange = 4'd14;
  localparam logic [3:0] SelTop = 4'd15;
  localparam logic [2:0] CaptureLimitAddr = {RegCaptureLimit, 2'b00};
  localparam int RandomPhases = 6;
  localparam int ItemsPerPhase = 125;
  localparam int FillFrames = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  frame_type;
    logic        rx_error;
    logic [15:0] signal_length;
    logic [15:0] payload_length;
    logic        slot_available;
    logic        queue_accepts;
    logic [3:0]  counter_index;
  } rx_event_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] copy_length;
    logic        was_truncated;
    logic        empty_payload;
    logic        return_slot;
    logic [15:0] occupancy;
    logic [31:0] counter_value;
  } fate_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [2:0]  frame_type = '0;
  logic        rx_error = 1'b0;
  logic [15:0] signal_length = '0;
  logic [15:0] payload_length = '0;
  logic        slot_available = 1'b0;
  logic        queue_accepts = 1'b0;
  logic [3:0]  counter_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  verdict;
  logic [15:0] copy_length;
  logic        was_truncated;
  logic        empty_payload;
  logic        return_slot;
  logic [15:0] occupancy;
  logic [31:0] counter_value;

  // admission model state
  counter_t    stat_cnt [NumCounters];
  logic [15:0] occ_level = '0;
  logic [15:0] occ_peak = '0;
  logic [15:0] cap_limit = CaptureLimitReset;

  rx_event_t   frame_q[$];
  fate_t       fates_due[$];
  rx_event_t   drv_event;
  fate_t       want;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;

  rx_frame_admission_stats u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .frame_type     (frame_type),
    .rx_error       (rx_error),
    .signal_length  (signal_length),
    .payload_length (payload_length),
    .slot_available (slot_available),
    .queue_accepts  (queue_accepts),
    .counter_index  (counter_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .copy_length    (copy_length),
    .was_truncated  (was_truncated),
    .empty_payload  (empty_payload),
    .return_slot    (return_slot),
    .occupancy      (occupancy),
    .counter_value  (counter_value)
  );

  always #10 clk = ~clk;

  initial begin
    foreach (stat_cnt[i]) stat_cnt[i] = '0;
  end

  // Work out the fate of one accepted event and queue it.
  function automatic void admit_event(input rx_event_t ev);
    fate_t       r;
    logic [15:0] len;
    r = '0;
    r.verdict = VerdictNonFrame;
    case (ev.kind)
      KindFrame: begin
        stat_cnt[CntTotal] += 1;
        if (ev.frame_type > TypeData) begin
          // misc frames ignore the receive error
          stat_cnt[CntMisc] += 1;
          r.verdict = VerdictMisc;
        end else begin
          if (ev.frame_type == TypeMgmt) stat_cnt[CntMgmt] += 1;
          else if (ev.frame_type == TypeCtrl) stat_cnt[CntCtrl] += 1;
          else stat_cnt[CntData] += 1;
          if (ev.rx_error) begin
            stat_cnt[CntErr] += 1;
            r.verdict = VerdictError;
          end else if (!ev.slot_available) begin
            stat_cnt[CntPool] += 1;
            r.verdict = VerdictPoolEmpty;
          end else if (!ev.queue_accepts) begin
            stat_cnt[CntQFull] += 1;
            r.verdict = VerdictQueueFull;
            r.return_slot = 1'b1;
          end else begin
            len = (ev.signal_length > cap_limit) ? cap_limit : ev.signal_length;
            if (len > ev.payload_length) len = ev.payload_length;
            r.verdict = VerdictQueued;
            r.copy_length = len;
            stat_cnt[CntQueued] += 1;
            if (ev.signal_length > cap_limit) begin
              stat_cnt[CntTrunc] += 1;
              r.was_truncated = 1'b1;
            end
            if (len == 16'd0) begin
              stat_cnt[CntEmpty] += 1;
              r.empty_payload = 1'b1;
            end
            if (occ_level != 16'hFFFF) occ_level += 1;
            if (occ_level > occ_peak) occ_peak = occ_level;
          end
        end
      end
      KindRelease: begin
        stat_cnt[CntProc] += 1;
        if (occ_level != 16'd0) occ_level -= 1;
        r.return_slot = 1'b1;
      end
      KindRead: begin
        if (ev.counter_index < NumCounters) r.counter_value = stat_cnt[ev.counter_index];
        else if (ev.counter_index == SelOccupancy) r.counter_value = {16'd0, occ_level};
        else if (ev.counter_index == SelPeak) r.counter_value = {16'd0, occ_peak};
      end
      default: ;
    endcase
    r.occupancy = occ_level;
    fates_due.push_back(r);
  endfunction

  function automatic rx_event_t mk_event(input logic [1:0] k, input logic [2:0] ft,
                                         input logic err, input logic [15:0] sig,
                                         input logic [15:0] pay, input logic slot,
                                         input logic q_ok, input logic [3:0] sel);
    rx_event_t ev;
    ev.kind = k;
    ev.frame_type = ft;
    ev.rx_error = err;
    ev.signal_length = sig;
    ev.payload_length = pay;
    ev.slot_available = slot;
    ev.queue_accepts = q_ok;
    ev.counter_index = sel;
    return ev;
  endfunction

  // Lengths cluster at the extremes, near the capture limit and at small values.
  function automatic logic [15:0] pick_length();
    int sel;
    int v;
    sel = $urandom_range(5);
    case (sel)
      0: v = $urandom_range(1) ? 65535 : 0;
      1: v = $urandom_range(64);
      2: v = int'(cap_limit) + $urandom_range(4) - 2;
      default: v = $urandom_range(65535);
    endcase
    return v[15:0];
  endfunction

  function automatic rx_event_t random_event();
    rx_event_t ev;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 50) ev.kind = KindFrame;
    else if (roll < 80) ev.kind = KindRelease;
    else if (roll < 97) ev.kind = KindRead;
    else ev.kind = KindUnused;
    ev.frame_type = ($urandom_range(99) < 85) ? 3'($urandom_range(TypeData, TypeMgmt))
                                              : 3'($urandom_range(TypeMiscHigh, TypeMiscLow));
    ev.rx_error = $urandom_range(99) < 10;
    ev.signal_length = pick_length();
    ev.payload_length = pick_length();
    ev.slot_available = $urandom_range(99) >= 10;
    ev.queue_accepts = $urandom_range(99) >= 10;
    ev.counter_index = 4'($urandom_range(15));
    return ev;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, exp_val, $time);
  endtask

  task automatic write_capture_limit(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CaptureLimitAddr;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_limit = value;
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_valid || fates_due.size() != 0) @(posedge clk);
  endtask

  // driver: present the next event once the current one has been transferred
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) admit_event(drv_event);
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_event = frame_q.pop_front();
        in_valid <= 1'b1;
        kind <= drv_event.kind;
        frame_type <= drv_event.frame_type;
        rx_error <= drv_event.rx_error;
        signal_length <= drv_event.signal_length;
        payload_length <= drv_event.payload_length;
        slot_available <= drv_event.slot_available;
        queue_accepts <= drv_event.queue_accepts;
        counter_index <= drv_event.counter_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each result transfer against the oldest expected fate
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fates_due.size() == 0) begin
          flag_mismatch("unexpected result", {29'd0, verdict}, '0);
        end else begin
          want = fates_due.pop_front();
          if (verdict !== want.verdict)
            flag_mismatch("verdict", 32'(verdict), 32'(want.verdict));
          if (copy_length !== want.copy_length)
            flag_mismatch("copy_length", 32'(copy_length), 32'(want.copy_length));
          if (was_truncated !== want.was_truncated)
            flag_mismatch("was_truncated", 32'(was_truncated), 32'(want.was_truncated));
          if (empty_payload !== want.empty_payload)
            flag_mismatch("empty_payload", 32'(empty_payload), 32'(want.empty_payload));
          if (return_slot !== want.return_slot)
            flag_mismatch("return_slot", 32'(return_slot), 32'(want.return_slot));
          if (occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
          if (counter_value !== want.counter_value)
            flag_mismatch("counter_value", counter_value, want.counter_value);
        end
      end
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [15:0] limit;
    int          mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed events under the reset capture limit
    send_idle_pct = 37;
    recv_idle_pct = 66;
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0, SelTop));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0,
                               4'(CntTotal)));
    frame_q.push_back(mk_event(KindFrame, TypeMgmt, 1'b0, 16'd2000, 16'hFFFF, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeCtrl, 1'b0, 16'd0, 16'd500, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeData, 1'b0, 16'hFFFF, 16'd0, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeData, 1'b0, 16'd1024, 16'd1024, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeData, 1'b0, 16'd1025, 16'd300, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeMiscHigh, 1'b1, 16'd60, 16'd60, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeMiscLow, 1'b0, 16'd60, 16'd60, 1'b1, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeMgmt, 1'b1, 16'd80, 16'd80, 1'b0, 1'b0, '0));
    frame_q.push_back(mk_event(KindFrame, TypeCtrl, 1'b0, 16'd80, 16'd80, 1'b0, 1'b1, '0));
    frame_q.push_back(mk_event(KindFrame, TypeData, 1'b0, 16'd80, 16'd80, 1'b1, 1'b0, '0));
    frame_q.push_back(mk_event(KindUnused, TypeMiscHigh, 1'b1, 16'hFFFF, 16'hFFFF,
                               1'b1, 1'b1, SelTop));
    // one release more than frames queued, so the last finds the queue empty
    repeat (6)
      frame_q.push_back(mk_event(KindRelease, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, 4'(CntProc)));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelOccupancy));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelPeak));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelOutOfRange));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, 4'(CntTrunc)));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, 4'(CntEmpty)));

    for (int p = 0; p < RandomPhases; p++) begin
      wait_drained();
      case (p)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = 16'($urandom_range(65534, 1));
        3: limit = 16'($urandom_range(300, 1));
        4: limit = CaptureLimitReset;
        default: limit = 16'($urandom_range(65535));
      endcase
      write_capture_limit(limit);
      mode = p / 2;
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 66 : 0;
      recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 37 : 0;
      repeat (ItemsPerPhase) frame_q.push_back(random_event());
    end

    // queue a burst of frames, then read and release
    wait_drained();
    write_capture_limit(16'($urandom_range(2000)));
    repeat (FillFrames)
      frame_q.push_back(mk_event(KindFrame, 3'($urandom_range(TypeData, TypeMgmt)), 1'b0,
                                 pick_length(), pick_length(), 1'b1, 1'b1,
                                 4'($urandom_range(15))));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelOccupancy));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelPeak));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, 4'(CntQueued)));
    repeat (2)
      frame_q.push_back(mk_event(KindRelease, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, '0));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelOccupancy));
    frame_q.push_back(mk_event(KindRead, TypeMgmt, 1'b0, '0, '0, 1'b0, 1'b0, SelPeak));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fates_due.size() != 0)
      flag_mismatch("results still outstanding", fates_due.size(), '0);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
